@@ rtl/fpss_pkg.sv @@
// shared constants, types and codes of the flash page and sector splitter
package fpss_pkg;

   localparam int PAGE_BYTES        = 256;
   localparam int SECTOR_BYTES      = 4096;
   localparam int FLASH_BYTES       = 8388608;
   localparam int MAX_REQUEST_BYTES = 16128;
   localparam int RUN_LIMIT         = 64;
   localparam int QUEUE_DEPTH       = 4;

   localparam int ADDR_W   = 23;
   localparam int COUNT_W  = 14;
   localparam int BYTES_W  = 13;
   localparam int CMD_W    = 2;
   localparam int WIDE_W   = 32;

   localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int ROOM_W       = PAGE_SHIFT + 1;
   localparam int RUN_W        = $clog2(RUN_LIMIT);
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PROGRAM = 2'd0,
      CMD_ERASE   = 2'd1,
      CMD_REJECT  = 2'd2,
      CMD_EMPTY   = 2'd3
   } command_type;

   // one classified request waiting for the emitter
   typedef struct packed {
      command_type        command;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] remaining;
      logic [RUN_W-1:0]   blocks_left;
   } job_type;

endpackage

@@ rtl/fpss_if.sv @@
// request and response channel interfaces of the flash splitter
interface fpss_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [fpss_pkg::ADDR_W-1:0]  start_address;
   logic [fpss_pkg::COUNT_W-1:0] byte_count;

   modport source (output valid, output operation, output start_address,
                   output byte_count, input ready);
   modport sink   (input valid, input operation, input start_address,
                   input byte_count, output ready);
endinterface

interface fpss_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fpss_pkg::CMD_W-1:0]   command;
   logic [fpss_pkg::ADDR_W-1:0]  chunk_address;
   logic [fpss_pkg::BYTES_W-1:0] chunk_bytes;
   logic                         last;

   modport source (output valid, output command, output chunk_address,
                   output chunk_bytes, output last, input ready);
   modport sink   (input valid, input command, input chunk_address,
                   input chunk_bytes, input last, output ready);
endinterface

@@ rtl/fpss_classify.sv @@
// front end: accepts requests and classifies them into jobs for the queue
module fpss_classify (
   fpss_req_if.sink          req_link,
   input  logic              queue_full,
   output logic              push_valid,
   output fpss_pkg::job_type push_job
);
   import fpss_pkg::*;

   logic [WIDE_W-1:0] start_w;
   logic [WIDE_W-1:0] count_w;
   logic [WIDE_W-1:0] offset;
   logic [WIDE_W-1:0] span;
   logic [WIDE_W-1:0] blocks_m1;
   logic              count_zero;
   logic              over_flash;
   logic              over_limit;
   logic              too_many;

   always_comb begin
      start_w    = WIDE_W'(req_link.start_address);
      count_w    = WIDE_W'(req_link.byte_count);
      count_zero = (req_link.byte_count == '0);
      over_flash = (start_w >= WIDE_W'(FLASH_BYTES)) ||
                   (start_w + count_w > WIDE_W'(FLASH_BYTES));
      over_limit = count_w > WIDE_W'(MAX_REQUEST_BYTES);
      // blocks touched minus one, from the offset inside the first block
      if (req_link.operation) begin
         offset    = start_w & WIDE_W'(SECTOR_BYTES - 1);
         span      = offset + count_w - WIDE_W'(1);
         blocks_m1 = span >> SECTOR_SHIFT;
      end else begin
         offset    = start_w & WIDE_W'(PAGE_BYTES - 1);
         span      = offset + count_w - WIDE_W'(1);
         blocks_m1 = span >> PAGE_SHIFT;
      end
      too_many = !count_zero && (blocks_m1 >= WIDE_W'(RUN_LIMIT));

      push_job.address     = req_link.start_address;
      push_job.remaining   = req_link.byte_count;
      push_job.blocks_left = blocks_m1[RUN_W-1:0];
      if (over_flash || over_limit || too_many) begin
         push_job.command = CMD_REJECT;
      end else if (count_zero) begin
         push_job.command = CMD_EMPTY;
      end else if (req_link.operation) begin
         push_job.command = CMD_ERASE;
         push_job.address = req_link.start_address & ~ADDR_W'(SECTOR_BYTES - 1);
      end else begin
         push_job.command = CMD_PROGRAM;
      end
   end

   assign req_link.ready = !queue_full;
   assign push_valid     = req_link.valid && !queue_full;

endmodule

@@ rtl/fpss_queue.sv @@
// short job queue between the classifier and the command emitter
module fpss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  fpss_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output fpss_pkg::job_type head_job
);
   import fpss_pkg::*;

   job_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_pop;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push_valid) - FILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/fpss_emitter.sv @@
// back end: walks one job at a time and emits its commands into the output register
module fpss_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  fpss_pkg::job_type head_job,
   output logic              pop,
   fpss_rsp_if.source        rsp_link
);
   import fpss_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } emit_state_type;

   emit_state_type      state_ff, state_in;
   job_type             cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]    command_ff;
   logic [ADDR_W-1:0]   address_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic                last_ff;

   logic                slot_free;
   logic                emit;
   logic [ROOM_W-1:0]   room;
   logic [COUNT_W-1:0]  room_c;
   logic [COUNT_W-1:0]  chunk_n;
   logic [BYTES_W-1:0]  gen_bytes;
   logic                gen_last;
   job_type             advanced;

   assign slot_free = !rsp_valid_ff || rsp_link.ready;

   always_comb begin
      // room left in the current page
      room     = ROOM_W'(PAGE_BYTES) - ROOM_W'(cur_ff.address[PAGE_SHIFT-1:0]);
      room_c   = COUNT_W'(room);
      chunk_n  = (room_c < cur_ff.remaining) ? room_c : cur_ff.remaining;
      advanced = cur_ff;
      case (cur_ff.command)
         CMD_PROGRAM: begin
            gen_bytes          = chunk_n[BYTES_W-1:0];
            gen_last           = (cur_ff.remaining == chunk_n);
            advanced.address   = cur_ff.address + ADDR_W'(chunk_n);
            advanced.remaining = cur_ff.remaining - chunk_n;
         end
         CMD_ERASE: begin
            gen_bytes            = BYTES_W'(SECTOR_BYTES);
            gen_last             = (cur_ff.blocks_left == '0);
            advanced.address     = cur_ff.address + ADDR_W'(SECTOR_BYTES);
            advanced.blocks_left = cur_ff.blocks_left - RUN_W'(1);
         end
         default: begin
            gen_bytes = '0;
            gen_last  = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               cur_in   = head_job;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               emit   = 1'b1;
               cur_in = advanced;
               if (gen_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_link.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         command_ff <= cur_ff.command;
         address_ff <= cur_ff.address;
         bytes_ff   <= gen_bytes;
         last_ff    <= gen_last;
      end
   end

   assign rsp_link.valid         = rsp_valid_ff;
   assign rsp_link.command       = command_ff;
   assign rsp_link.chunk_address = address_ff;
   assign rsp_link.chunk_bytes   = bytes_ff;
   assign rsp_link.last          = last_ff;

endmodule

@@ rtl/flash_page_sector_splitter_core.sv @@
// top level of the flash page and sector splitter
// Each request transaction (write or erase, start address, byte count) turns into a run of
// response transactions: page programs split at page boundaries, one sector erase per sector
// touched, or a single rejected or empty-done response; the final response of a run has last
// set. A request is classified in the cycle it is accepted and parked in a four-entry job
// queue, so requests keep flowing in while earlier runs are still being emitted. The emitter
// picks up a job in its idle state and then, in its run state, produces one command per
// cycle while the output register is free; a rejected or empty request yields a single
// command, and a write yields at most 64 page programs.
module flash_page_sector_splitter_core (
   input logic        clock,
   input logic        reset,
   fpss_req_if.sink   req_link,
   fpss_rsp_if.source rsp_link
);
   import fpss_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    queue_not_empty;
   job_type head_job;
   logic    pop;

   fpss_classify u_classify (
      .req_link   (req_link),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   fpss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_job   (head_job)
   );

   fpss_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_link  (rsp_link)
   );

   // rejected and empty results are single-transaction runs with no bytes
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_link.valid && (rsp_link.command == CMD_REJECT || rsp_link.command == CMD_EMPTY))
      |-> (rsp_link.last && rsp_link.chunk_bytes == '0))
      else $error("reject or empty result without last or with bytes");

   // a page program never crosses a page boundary and is never empty
   a_program_in_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_link.valid && rsp_link.command == CMD_PROGRAM)
      |-> (rsp_link.chunk_bytes != '0 &&
           (WIDE_W'(rsp_link.chunk_address[PAGE_SHIFT-1:0]) + WIDE_W'(rsp_link.chunk_bytes)
            <= WIDE_W'(PAGE_BYTES))))
      else $error("page program chunk crosses a page boundary");

   // sector erases are aligned
   a_erase_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_link.valid && rsp_link.command == CMD_ERASE)
      |-> (rsp_link.chunk_address[SECTOR_SHIFT-1:0] == '0))
      else $error("sector erase at unaligned address");

   // the queue never takes a job while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push_valid)
      else $error("job queue overflow");

endmodule
